>>> hw/rtl/bfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the blend function of the bilinear frame scaler.
package bfs_pkg;

    localparam int SRC_WIDTH_DEF  = 640;
    localparam int SRC_HEIGHT_DEF = 480;

    localparam int POS_W       = 12;
    localparam int COLOR_W     = 24;
    localparam int SIZE_W      = 13;
    localparam int CFG_IDX_W   = 8;
    localparam int QUO_W       = 13;
    localparam int REM_W       = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int HALF_ONE    = 32768;

    localparam logic [SIZE_W-1:0] OUT_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] OUT_HEIGHT_RST = 13'd480;
    localparam logic [SIZE_W-1:0] SIZE_MIN       = 13'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX       = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 8'd1;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic {
        KIND_WRITE,
        KIND_REQUEST
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [COLOR_W-1:0] color;
    } entry_t;

    function automatic logic [7:0] lerp8(input logic [7:0] p, input logic [7:0] q,
                                         input logic [7:0] w);
        logic [16:0] acc;
        acc = 17'(p) * (17'd256 - 17'(w)) + 17'(q) * 17'(w);
        return acc[15:8];
    endfunction

endpackage

>>> hw/rtl/bfs_recip.sv
`timescale 1ns / 1ps
// Size registers and the shared iterative divider that derives the sampling steps.
module bfs_recip #(
    parameter int SRC_WIDTH  = bfs_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = bfs_pkg::SRC_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfs_pkg::SIZE_W-1:0]          cfg_data,
    output logic                                busy,
    output logic [bfs_pkg::SIZE_W-1:0]          h_eff,
    output logic [$clog2(SRC_WIDTH)+16:0]       step_x,
    output logic [$clog2(SRC_HEIGHT)+15:0]      qh,
    output logic [bfs_pkg::REM_W-1:0]           rh
);
    import bfs_pkg::*;

    localparam int SX_W  = $clog2(SRC_WIDTH) + 17;
    localparam int QH_W  = $clog2(SRC_HEIGHT) + 16;
    localparam int DIV_W = (SX_W > QH_W) ? SX_W : QH_W;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int RB_W  = SIZE_W + 1;
    localparam logic [DIV_W-1:0] X_NUM = DIV_W'(SRC_WIDTH) << 16;
    localparam logic [DIV_W-1:0] Y_NUM = DIV_W'(SRC_HEIGHT) << 15;
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(DIV_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   num_next;
    logic [RB_W-1:0]    rem_reg;
    logic [RB_W-1:0]    rem_next;
    logic [RB_W-1:0]    rem_shift;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  divisor;
    logic [SX_W-1:0]    step_x_reg;
    logic [QH_W-1:0]    qh_reg;
    logic [REM_W-1:0]   rh_reg;
    logic               cfg_fire;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign w_eff     = clamp_size(width_reg);
    assign h_eff     = clamp_size(height_reg);
    assign divisor   = (state_reg == ST_DIV_Y) ? h_eff : w_eff;
    assign rem_shift = {rem_reg[SIZE_W-1:0], num_reg[DIV_W-1]};

    always_comb
    begin
        if (rem_shift >= RB_W'(divisor))
        begin
            rem_next = rem_shift - RB_W'(divisor);
            num_next = {num_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            num_next = {num_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= OUT_WIDTH_RST;
            height_reg <= OUT_HEIGHT_RST;
            state_reg  <= ST_DIV_X;
            cnt_reg    <= '0;
            num_reg    <= X_NUM;
            rem_reg    <= '0;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_OUT_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_OUT_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            state_reg <= ST_DIV_X;
            cnt_reg   <= '0;
            num_reg   <= X_NUM;
            rem_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_DIV_X:
                begin
                    if (cnt_reg == LAST)
                    begin
                        step_x_reg <= num_next[SX_W-1:0];
                        num_reg    <= Y_NUM;
                        rem_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_DIV_Y;
                    end
                    else
                    begin
                        num_reg <= num_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV_Y:
                begin
                    if (cnt_reg == LAST)
                    begin
                        qh_reg    <= num_next[QH_W-1:0];
                        rh_reg    <= rem_next[REM_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        num_reg <= num_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign step_x = step_x_reg;
    assign qh     = qh_reg;
    assign rh     = rh_reg;

endmodule

>>> hw/rtl/bfs_front.sv
`timescale 1ns / 1ps
// Input stage that accepts beats, drops writes outside the frame and feeds the queue.
module bfs_front #(
    parameter int SRC_WIDTH  = bfs_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = bfs_pkg::SRC_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [bfs_pkg::POS_W-1:0]     pos_x,
    input  logic [bfs_pkg::POS_W-1:0]     pos_y,
    input  logic [bfs_pkg::COLOR_W-1:0]   source_color,
    input  logic                          busy,
    input  logic                          q_ready,
    output logic                          push,
    output bfs_pkg::entry_t               push_data
);
    import bfs_pkg::*;

    logic   f_valid_reg;
    entry_t f_entry_reg;
    logic   accept;
    logic   keep;

    assign in_ready = !busy && (!f_valid_reg || q_ready);
    assign accept   = in_valid && in_ready;
    assign keep     = (opcode == OP_REQUEST)
                   || (({1'b0, pos_x} < (POS_W + 1)'(SRC_WIDTH))
                   &&  ({1'b0, pos_y} < (POS_W + 1)'(SRC_HEIGHT)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg       <= keep;
            f_entry_reg.kind  <= (opcode == OP_REQUEST) ? KIND_REQUEST : KIND_WRITE;
            f_entry_reg.px    <= pos_x;
            f_entry_reg.py    <= pos_y;
            f_entry_reg.color <= source_color;
        end
        else if (q_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    assign push      = f_valid_reg && q_ready;
    assign push_data = f_entry_reg;

endmodule

>>> hw/rtl/bfs_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue between the input stage and the sampling pipeline.
module bfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bfs_pkg::entry_t push_data,
    output logic            ready,
    output logic            valid,
    output bfs_pkg::entry_t head,
    input  logic            pop
);
    import bfs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    entry_t             slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/bfs_back.sv
`timescale 1ns / 1ps
// Sampling pipeline: position math, row divider, banked frame store, blend and output register.
module bfs_back #(
    parameter int SRC_WIDTH  = bfs_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = bfs_pkg::SRC_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bfs_pkg::SIZE_W-1:0]       h_eff,
    input  logic [$clog2(SRC_WIDTH)+16:0]    step_x,
    input  logic [$clog2(SRC_HEIGHT)+15:0]   qh,
    input  logic [bfs_pkg::REM_W-1:0]        rh,
    input  logic                             q_valid,
    input  bfs_pkg::entry_t                  q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bfs_pkg::COLOR_W-1:0]      out_pixel
);
    import bfs_pkg::*;

    localparam int XW    = $clog2(SRC_WIDTH);
    localparam int YW    = $clog2(SRC_HEIGHT);
    localparam int SX_W  = XW + 17;
    localparam int QH_W  = YW + 16;
    localparam int PX_W  = SX_W + POS_W;
    localparam int FX_W  = PX_W + 2;
    localparam int QP_W  = QH_W + POS_W + 1;
    localparam int FY_W  = QP_W + 2;
    localparam int RN_W  = REM_W + POS_W + 1;
    localparam int HW    = (SRC_WIDTH + 1) / 2;
    localparam int HH    = (SRC_HEIGHT + 1) / 2;
    localparam int DEPTH = HW * HH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FX_W-1:0] MAX_FX = FX_W'(SRC_WIDTH - 1) << 16;
    localparam logic [FY_W-1:0] MAX_FY = FY_W'(SRC_HEIGHT - 1) << 16;
    localparam logic [XW-1:0]   XLAST  = XW'(SRC_WIDTH - 1);
    localparam logic [YW-1:0]   YLAST  = YW'(SRC_HEIGHT - 1);

    typedef struct packed {
        kind_t              kind;
        logic [XW-1:0]      x0;
        logic [XW-1:0]      x1;
        logic [7:0]         wx;
        logic [POS_W-1:0]   py;
        logic [COLOR_W-1:0] color;
        logic [QP_W-1:0]    prodq;
        logic [RN_W-1:0]    rem;
        logic [QUO_W-1:0]   quo;
    } dstg_t;

    logic adv;

    logic               sa_valid_reg;
    kind_t              sa_kind_reg;
    logic [POS_W-1:0]   sa_px_reg;
    logic [POS_W-1:0]   sa_py_reg;
    logic [COLOR_W-1:0] sa_color_reg;
    logic [PX_W-1:0]    sa_prodx_reg;
    logic [QP_W-1:0]    sa_prodq_reg;
    logic [RN_W-1:0]    sa_nrem_reg;
    logic [POS_W:0]     odd_y;

    logic signed [FX_W-1:0] fx;
    logic [FX_W-1:0]        fxc;
    logic [XW-1:0]          bx0;
    logic [XW-1:0]          bx1;

    logic  dv_reg [0:QUO_W];
    dstg_t d_reg  [0:QUO_W];

    logic signed [FY_W-1:0] fy;
    logic [FY_W-1:0]        fyc;
    logic [YW-1:0]          cy0;
    logic [YW-1:0]          cy1;

    logic               sc_valid_reg;
    kind_t              sc_kind_reg;
    logic [XW-1:0]      sc_x0_reg;
    logic [XW-1:0]      sc_x1_reg;
    logic [YW-1:0]      sc_y0_reg;
    logic [YW-1:0]      sc_y1_reg;
    logic [7:0]         sc_wx_reg;
    logic [7:0]         sc_wy_reg;
    logic [COLOR_W-1:0] sc_color_reg;

    logic [AW-1:0]      bank_addr [0:3];
    logic [3:0]         bank_we;

    logic               sd_valid_reg;
    kind_t              sd_kind_reg;
    logic [AW-1:0]      sd_addr_reg [0:3];
    logic [3:0]         sd_we_reg;
    logic [COLOR_W-1:0] sd_color_reg;
    logic               sd_x0p_reg;
    logic               sd_x1p_reg;
    logic               sd_y0p_reg;
    logic               sd_y1p_reg;
    logic [7:0]         sd_wx_reg;
    logic [7:0]         sd_wy_reg;

    logic [COLOR_W-1:0] rd_reg [0:3];
    logic               se_valid_reg;
    kind_t              se_kind_reg;
    logic               se_x0p_reg;
    logic               se_x1p_reg;
    logic               se_y0p_reg;
    logic               se_y1p_reg;
    logic [7:0]         se_wx_reg;
    logic [7:0]         se_wy_reg;

    logic [COLOR_W-1:0] pa;
    logic [COLOR_W-1:0] pb;
    logic [COLOR_W-1:0] pc;
    logic [COLOR_W-1:0] pd;
    logic [COLOR_W-1:0] top_mix;
    logic [COLOR_W-1:0] bot_mix;

    logic               sf_valid_reg;
    kind_t              sf_kind_reg;
    logic [COLOR_W-1:0] sf_top_reg;
    logic [COLOR_W-1:0] sf_bot_reg;
    logic [7:0]         sf_wy_reg;
    logic [COLOR_W-1:0] final_mix;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_pixel_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;
    assign odd_y = {q_head.py, 1'b1};

    always_comb
    begin
        fx = $signed(FX_W'(step_x >> 1)) + $signed(FX_W'(sa_prodx_reg))
           - $signed(FX_W'(HALF_ONE));
        if (fx < 0)
        begin
            fxc = '0;
        end
        else if (fx > $signed(MAX_FX))
        begin
            fxc = MAX_FX;
        end
        else
        begin
            fxc = $unsigned(fx);
        end
        if (sa_kind_reg == KIND_WRITE)
        begin
            bx0 = sa_px_reg[XW-1:0];
            bx1 = sa_px_reg[XW-1:0];
        end
        else
        begin
            bx0 = fxc[16 +: XW];
            bx1 = (fxc[16 +: XW] == XLAST) ? fxc[16 +: XW] : fxc[16 +: XW] + 1'b1;
        end
    end

    always_comb
    begin
        fy = $signed(FY_W'(d_reg[QUO_W].prodq)) + $signed(FY_W'(d_reg[QUO_W].quo))
           - $signed(FY_W'(HALF_ONE));
        if (fy < 0)
        begin
            fyc = '0;
        end
        else if (fy > $signed(MAX_FY))
        begin
            fyc = MAX_FY;
        end
        else
        begin
            fyc = $unsigned(fy);
        end
        if (d_reg[QUO_W].kind == KIND_WRITE)
        begin
            cy0 = d_reg[QUO_W].py[YW-1:0];
            cy1 = d_reg[QUO_W].py[YW-1:0];
        end
        else
        begin
            cy0 = fyc[16 +: YW];
            cy1 = (fyc[16 +: YW] == YLAST) ? fyc[16 +: YW] : fyc[16 +: YW] + 1'b1;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [RN_W-1:0] dsh;
        logic            ge;
        dstg_t           nxt;

        assign dsh = RN_W'(h_eff) << SH;
        assign ge  = (d_reg[k].rem >= dsh);

        always_comb
        begin
            nxt = d_reg[k];
            if (ge)
            begin
                nxt.rem     = d_reg[k].rem - dsh;
                nxt.quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k+1] <= dv_reg[k];
                d_reg[k+1]  <= nxt;
            end
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic RY = 1'(b >> 1);
        localparam logic RX = 1'(b & 1);
        logic [YW-1:0]      yr;
        logic [XW-1:0]      xc;
        logic [COLOR_W-1:0] mem [0:DEPTH-1];

        assign yr           = (sc_y0_reg[0] == RY) ? sc_y0_reg : sc_y1_reg;
        assign xc           = (sc_x0_reg[0] == RX) ? sc_x0_reg : sc_x1_reg;
        assign bank_addr[b] = AW'(AW'(yr >> 1) * AW'(HW) + AW'(xc >> 1));
        assign bank_we[b]   = (sc_kind_reg == KIND_WRITE) && (sc_y0_reg[0] == RY)
                           && (sc_x0_reg[0] == RX);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sd_valid_reg && sd_we_reg[b])
                begin
                    mem[sd_addr_reg[b]] <= sd_color_reg;
                end
                rd_reg[b] <= mem[sd_addr_reg[b]];
            end
        end
    end

    assign pa = rd_reg[{se_y0p_reg, se_x0p_reg}];
    assign pb = rd_reg[{se_y0p_reg, se_x1p_reg}];
    assign pc = rd_reg[{se_y1p_reg, se_x0p_reg}];
    assign pd = rd_reg[{se_y1p_reg, se_x1p_reg}];

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        assign top_mix[8*ch +: 8]   = lerp8(pa[8*ch +: 8], pb[8*ch +: 8], se_wx_reg);
        assign bot_mix[8*ch +: 8]   = lerp8(pc[8*ch +: 8], pd[8*ch +: 8], se_wx_reg);
        assign final_mix[8*ch +: 8] = lerp8(sf_top_reg[8*ch +: 8], sf_bot_reg[8*ch +: 8],
                                            sf_wy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            dv_reg[0]     <= 1'b0;
            sc_valid_reg  <= 1'b0;
            sd_valid_reg  <= 1'b0;
            se_valid_reg  <= 1'b0;
            sf_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= q_valid;
            sa_kind_reg  <= q_head.kind;
            sa_px_reg    <= q_head.px;
            sa_py_reg    <= q_head.py;
            sa_color_reg <= q_head.color;
            sa_prodx_reg <= PX_W'(q_head.px) * PX_W'(step_x);
            sa_prodq_reg <= QP_W'(odd_y) * QP_W'(qh);
            sa_nrem_reg  <= RN_W'(odd_y) * RN_W'(rh);

            dv_reg[0]       <= sa_valid_reg;
            d_reg[0].kind   <= sa_kind_reg;
            d_reg[0].x0     <= bx0;
            d_reg[0].x1     <= bx1;
            d_reg[0].wx     <= fxc[15:8];
            d_reg[0].py     <= sa_py_reg;
            d_reg[0].color  <= sa_color_reg;
            d_reg[0].prodq  <= sa_prodq_reg;
            d_reg[0].rem    <= sa_nrem_reg;
            d_reg[0].quo    <= '0;

            sc_valid_reg <= dv_reg[QUO_W];
            sc_kind_reg  <= d_reg[QUO_W].kind;
            sc_x0_reg    <= d_reg[QUO_W].x0;
            sc_x1_reg    <= d_reg[QUO_W].x1;
            sc_wx_reg    <= d_reg[QUO_W].wx;
            sc_y0_reg    <= cy0;
            sc_y1_reg    <= cy1;
            sc_wy_reg    <= fyc[15:8];
            sc_color_reg <= d_reg[QUO_W].color;

            sd_valid_reg <= sc_valid_reg;
            sd_kind_reg  <= sc_kind_reg;
            sd_we_reg    <= bank_we;
            sd_color_reg <= sc_color_reg;
            sd_x0p_reg   <= sc_x0_reg[0];
            sd_x1p_reg   <= sc_x1_reg[0];
            sd_y0p_reg   <= sc_y0_reg[0];
            sd_y1p_reg   <= sc_y1_reg[0];
            sd_wx_reg    <= sc_wx_reg;
            sd_wy_reg    <= sc_wy_reg;
            for (int i = 0; i < 4; i++)
            begin
                sd_addr_reg[i] <= bank_addr[i];
            end

            se_valid_reg <= sd_valid_reg;
            se_kind_reg  <= sd_kind_reg;
            se_x0p_reg   <= sd_x0p_reg;
            se_x1p_reg   <= sd_x1p_reg;
            se_y0p_reg   <= sd_y0p_reg;
            se_y1p_reg   <= sd_y1p_reg;
            se_wx_reg    <= sd_wx_reg;
            se_wy_reg    <= sd_wy_reg;

            sf_valid_reg <= se_valid_reg;
            sf_kind_reg  <= se_kind_reg;
            sf_top_reg   <= top_mix;
            sf_bot_reg   <= bot_mix;
            sf_wy_reg    <= se_wy_reg;

            out_valid_reg <= sf_valid_reg && (sf_kind_reg == KIND_REQUEST);
            out_pixel_reg <= final_mix;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

>>> hw/rtl/bilinear_frame_scaler_core.sv
`timescale 1ns / 1ps
// Top level of the bilinear frame scaler.
// The scaler holds one RGB source frame in four memory banks split by row and column
// parity, so the four neighbors of a sample are read in the same cycle, and it accepts
// one beat per clock while in_ready is high: a source pixel write (opcode 0) or an output
// pixel request (opcode 1), with one result beat per request, in order. A queue of four
// entries and an output register let the input keep flowing while the output stalls,
// until the queue is full. After reset and after every write to out_width or out_height,
// a shared one-bit-per-cycle divider recomputes first the horizontal step and then the
// row constants, during which in_ready is low.
// The per-row division is done in a 13-stage pipelined divider inside the sample pipeline.
module bilinear_frame_scaler_core #(
    parameter int SRC_WIDTH  = bfs_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = bfs_pkg::SRC_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [bfs_pkg::POS_W-1:0]         pos_x,
    input  logic [bfs_pkg::POS_W-1:0]         pos_y,
    input  logic [bfs_pkg::COLOR_W-1:0]       source_color,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bfs_pkg::COLOR_W-1:0]       out_pixel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfs_pkg::SIZE_W-1:0]        cfg_data
);
    import bfs_pkg::*;

    localparam int SX_W = $clog2(SRC_WIDTH) + 17;
    localparam int QH_W = $clog2(SRC_HEIGHT) + 16;

    logic               busy;
    logic [SIZE_W-1:0]  h_eff;
    logic [SX_W-1:0]    step_x;
    logic [QH_W-1:0]    qh;
    logic [REM_W-1:0]   rh;
    logic               push;
    entry_t             push_data;
    logic               q_ready;
    logic               q_valid;
    entry_t             q_head;
    logic               q_pop;

    bfs_recip #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .h_eff     (h_eff),
        .step_x    (step_x),
        .qh        (qh),
        .rh        (rh)
    );

    bfs_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .source_color (source_color),
        .busy         (busy),
        .q_ready      (q_ready),
        .push         (push),
        .push_data    (push_data)
    );

    bfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    bfs_back #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .h_eff     (h_eff),
        .step_x    (step_x),
        .qh        (qh),
        .rh        (rh),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel)
    );

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("input beat offered while step constants are being computed");

    a_cfg_restarts_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> busy)
        else $error("size register write did not restart the divider");

    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !q_pop)
        else $error("queue popped while the output beat is stalled");

endmodule
